/* hdl/windowed_throughput_meter_macros.svh */
// Assertion macros shared by the windowed throughput meter RTL.
// No dependencies; compiled before every file that asserts.
`ifndef WINDOWED_THROUGHPUT_METER_MACROS_SVH
`define WINDOWED_THROUGHPUT_METER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge.
`define WTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication.
`define WTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define WTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/wtm_pkg.sv */
// Shared constants, payload structs and control/status structs of the
// windowed throughput meter. No dependencies.
package wtm_pkg;

    localparam int HIST_DEPTH  = 60;
    localparam int WIN_COUNT   = 4;
    localparam int OUT_WINDOWS = 4;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int WIN_IW      = (WIN_COUNT > 1) ? $clog2(WIN_COUNT) : 1;

    localparam int BYTE_W   = 64;
    localparam int TIME_W   = 48;
    localparam int CNT_W    = 32;
    localparam int RATE_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int WLEN_W   = 6;
    localparam int SLOT_W   = (HIST_AW + 1 > WLEN_W) ? HIST_AW + 1 : WLEN_W;

    // bytes * 1000 fits in 74 bits
    localparam int NUM_W  = BYTE_W + 10;
    localparam int HI_W   = NUM_W - RATE_W;
    localparam int CMP_W  = (HI_W > TIME_W) ? HI_W : TIME_W;
    localparam int DIV_CW = $clog2(RATE_W + 1);
    localparam int T24_W  = BYTE_W + 5;

    localparam int CFG_DW = 16;
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_PERIOD    = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] CFG_WIN_FIRST = CFG_IW'(1);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

    function automatic logic [WLEN_W-1:0] win_reset(input int idx);
        logic [WLEN_W-1:0] v;
        case (idx)
            0:       v = WLEN_W'(1);
            1:       v = WLEN_W'(5);
            2:       v = WLEN_W'(20);
            default: v = WLEN_W'(60);
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic [CNT_W-1:0]  byte_count;
        logic [TIME_W-1:0] now_ms;
    } t_wtm_in;

    typedef struct packed {
        logic [BYTE_W-1:0] total_received;
        logic              sampled;
        logic [RATE_W-1:0] rate_a;
        logic [RATE_W-1:0] rate_b;
        logic [RATE_W-1:0] rate_c;
        logic [RATE_W-1:0] rate_d;
        logic [RATE_W-1:0] peak_a;
        logic [RATE_W-1:0] peak_b;
        logic [RATE_W-1:0] peak_c;
        logic [RATE_W-1:0] peak_d;
        logic [TIME_W-1:0] stall_since_ms;
    } t_wtm_out;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [BYTE_W-1:0] bytes;
    } t_wtm_hist;

    typedef struct packed {
        logic cap_in;
        logic add;
        logic decide;
        logic stall;
        logic rd_win;
        logic win_diff;
        logic mul1;
        logic mul2;
        logic div_start;
        logic win_upd;
        logic push;
        logic load_out;
    } t_wtm_cmd;

    typedef struct packed {
        logic fire;
        logic div_busy;
        logic div_done;
        logic last_win;
    } t_wtm_sts;

endpackage

/* hdl/wtm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

/* hdl/wtm_div.sv */
// Restoring divider, one quotient bit per cycle, saturating at the quotient width.
// Depends on wtm_pkg.
module wtm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wtm_pkg::NUM_W-1:0]  i_num,
    input  logic [wtm_pkg::TIME_W-1:0] i_den,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [wtm_pkg::RATE_W-1:0] o_quot
);
    import wtm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [TIME_W-1:0] r_rem;
    logic [RATE_W-1:0] r_q;
    logic              w_sat;
    logic [TIME_W+1:0] w_trial;

    // quotient overflows when the upper numerator part already reaches the divisor
    assign w_sat   = CMP_W'(i_num[NUM_W-1:RATE_W]) >= CMP_W'(i_den);
    assign w_trial = {1'b0, r_rem, r_q[RATE_W-1]} - {2'b00, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (w_sat) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= DIV_CW'(RATE_W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= TIME_W'(i_num[NUM_W-1:RATE_W]);
            r_q   <= w_sat ? '1 : i_num[RATE_W-1:0];
        end else if (r_busy) begin
            if (!w_trial[TIME_W+1]) begin
                r_rem <= w_trial[TIME_W-1:0];
            end else begin
                r_rem <= {r_rem[TIME_W-2:0], r_q[RATE_W-1]};
            end
            r_q <= {r_q[RATE_W-2:0], !w_trial[TIME_W+1]};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* hdl/wtm_dp.sv */
// Datapath of the throughput meter: registers, history RAM, window arithmetic.
// Depends on wtm_pkg, wtm_ram and wtm_div.
module wtm_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [wtm_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [wtm_pkg::CFG_DW-1:0] i_cfg_data,
    input  wtm_pkg::t_wtm_in           i_in_data,
    input  wtm_pkg::t_wtm_cmd          i_cmd,
    output wtm_pkg::t_wtm_sts          o_sts,
    output wtm_pkg::t_wtm_out          o_out_data
);
    import wtm_pkg::*;

    logic [PERIOD_W-1:0]   r_period;
    logic [WLEN_W-1:0]     r_win [WIN_COUNT];
    logic [CNT_W-1:0]      r_cnt;
    logic [TIME_W-1:0]     r_now;
    logic [BYTE_W-1:0]     r_total;
    logic [TIME_W-1:0]     r_last;
    logic [TIME_W-1:0]     r_since;
    logic                  r_sampled;
    logic [TIME_W-1:0]     r_stall;
    logic [HIST_AW-1:0]    r_head;
    logic [HIST_DEPTH-1:0] r_hvalid;
    logic                  r_rd_valid;
    logic [WIN_IW-1:0]     r_widx;
    logic [BYTE_W-1:0]     r_b;
    logic [TIME_W-1:0]     r_dt;
    logic [T24_W-1:0]      r_t24;
    logic [NUM_W-1:0]      r_n;
    logic [RATE_W-1:0]     r_rate [WIN_COUNT];
    logic [RATE_W-1:0]     r_peak [WIN_COUNT];
    t_wtm_out              r_out;

    logic [HIST_AW-1:0] n_head;
    logic [HIST_AW-1:0] w_newest;
    logic [SLOT_W-1:0]  w_wlen;
    logic [SLOT_W-1:0]  w_head_e;
    logic [SLOT_W-1:0]  w_slot_e;
    logic [HIST_AW-1:0] w_raddr;
    logic               w_re;
    logic               w_fire;
    logic               w_last_win;
    t_wtm_hist          w_ram_q;
    t_wtm_hist          w_hist;
    logic               w_div_busy;
    logic               w_div_done;
    logic [RATE_W-1:0]  w_quot;
    logic [RATE_W-1:0]  w_rate_o [OUT_WINDOWS];
    logic [RATE_W-1:0]  w_peak_o [OUT_WINDOWS];

    assign w_fire     = r_since >= TIME_W'(r_period);
    assign w_last_win = r_widx == WIN_IW'(WIN_COUNT - 1);
    assign w_newest   = (r_head == '0) ? HIST_AW'(HIST_DEPTH - 1) : r_head - 1'b1;
    assign n_head     = (r_head == HIST_AW'(HIST_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // clamp the window length and find the slot pushed that many samples ago
    always_comb begin
        w_wlen = SLOT_W'(r_win[r_widx]);
        if (w_wlen == '0) begin
            w_wlen = SLOT_W'(1);
        end else if (w_wlen > SLOT_W'(HIST_DEPTH)) begin
            w_wlen = SLOT_W'(HIST_DEPTH);
        end
        w_head_e = SLOT_W'(r_head);
        if (w_head_e >= w_wlen) begin
            w_slot_e = w_head_e - w_wlen;
        end else begin
            w_slot_e = w_head_e + SLOT_W'(HIST_DEPTH) - w_wlen;
        end
    end

    assign w_re    = i_cmd.decide | i_cmd.rd_win;
    assign w_raddr = i_cmd.decide ? w_newest : w_slot_e[HIST_AW-1:0];
    // never-written slots read as zero
    assign w_hist  = r_rd_valid ? w_ram_q : '0;

    wtm_ram #(
        .WIDTH ($bits(t_wtm_hist)),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_head),
        .i_wdata ({r_now, r_total}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    wtm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_n),
        .i_den   (r_dt),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            for (int i = 0; i < WIN_COUNT; i++) begin
                r_win[i]  <= win_reset(i);
                r_rate[i] <= '0;
                r_peak[i] <= '0;
            end
            r_total  <= '0;
            r_last   <= '0;
            r_stall  <= '0;
            r_head   <= '0;
            r_hvalid <= '0;
            r_widx   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PERIOD) begin
                    r_period <= i_cfg_data[PERIOD_W-1:0];
                end
                for (int i = 0; i < WIN_COUNT; i++) begin
                    if (i < OUT_WINDOWS && i_cfg_idx == CFG_IW'(int'(CFG_WIN_FIRST) + i)) begin
                        r_win[i] <= i_cfg_data[WLEN_W-1:0];
                    end
                end
            end
            if (i_cmd.add) begin
                r_total <= r_total + BYTE_W'(r_cnt);
            end
            if (i_cmd.stall) begin
                r_last <= r_now;
                if (r_total == w_hist.bytes) begin
                    if (r_stall == '0) begin
                        r_stall <= r_now;
                    end
                end else begin
                    r_stall <= '0;
                end
            end
            if (i_cmd.decide) begin
                r_widx <= '0;
            end else if (i_cmd.win_upd) begin
                r_widx <= w_last_win ? '0 : r_widx + 1'b1;
            end
            // hold rate and peak when the window spans no time
            if (i_cmd.win_upd && r_dt != '0) begin
                r_rate[r_widx] <= w_quot;
                if (w_quot > r_peak[r_widx]) begin
                    r_peak[r_widx] <= w_quot;
                end
            end
            if (i_cmd.push) begin
                r_head           <= n_head;
                r_hvalid[r_head] <= 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < OUT_WINDOWS; i++) begin
            w_rate_o[i] = '0;
            w_peak_o[i] = '0;
            if (i < WIN_COUNT) begin
                w_rate_o[i] = r_rate[WIN_IW'(i % WIN_COUNT)];
                w_peak_o[i] = r_peak[WIN_IW'(i % WIN_COUNT)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_cnt <= i_in_data.byte_count;
            r_now <= i_in_data.now_ms;
        end
        if (i_cmd.add) begin
            r_since <= r_now - r_last;
        end
        if (i_cmd.decide) begin
            r_sampled <= w_fire;
        end
        if (w_re) begin
            r_rd_valid <= r_hvalid[w_raddr];
        end
        if (i_cmd.win_diff) begin
            r_b  <= r_total - w_hist.bytes;
            r_dt <= r_now - w_hist.time_ms;
        end
        // bytes * 1000 = bytes * 1024 - bytes * 24
        if (i_cmd.mul1) begin
            r_t24 <= {1'b0, r_b, 4'b0000} + {2'b00, r_b, 3'b000};
        end
        if (i_cmd.mul2) begin
            r_n <= {r_b, 10'b0} - {5'b00000, r_t24};
        end
        if (i_cmd.load_out) begin
            r_out.total_received <= r_total;
            r_out.sampled        <= r_sampled;
            r_out.rate_a         <= w_rate_o[0];
            r_out.rate_b         <= w_rate_o[1];
            r_out.rate_c         <= w_rate_o[2];
            r_out.rate_d         <= w_rate_o[3];
            r_out.peak_a         <= w_peak_o[0];
            r_out.peak_b         <= w_peak_o[1];
            r_out.peak_c         <= w_peak_o[2];
            r_out.peak_d         <= w_peak_o[3];
            r_out.stall_since_ms <= r_stall;
        end
    end

    assign o_sts.fire     = w_fire;
    assign o_sts.div_busy = w_div_busy;
    assign o_sts.div_done = w_div_done;
    assign o_sts.last_win = w_last_win;
    assign o_out_data     = r_out;

endmodule

/* hdl/wtm_ctrl.sv */
// Sequencer of the throughput meter: steps the datapath through one request.
// Depends on wtm_pkg and the assertion macro header.
`include "windowed_throughput_meter_macros.svh"
module wtm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  wtm_pkg::t_wtm_sts i_sts,
    output wtm_pkg::t_wtm_cmd o_cmd
);
    import wtm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_DECIDE,
        S_STALL,
        S_WIN_RD,
        S_WIN_DIFF,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_WAIT,
        S_PUSH,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_full;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_sts.fire ? S_STALL : S_OUT;
            end
            S_STALL: begin
                o_cmd.stall = 1'b1;
                n_state     = S_WIN_RD;
            end
            S_WIN_RD: begin
                o_cmd.rd_win = 1'b1;
                n_state      = S_WIN_DIFF;
            end
            S_WIN_DIFF: begin
                o_cmd.win_diff = 1'b1;
                n_state        = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.win_upd = 1'b1;
                    n_state       = i_sts.last_win ? S_PUSH : S_WIN_RD;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!r_out_full || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_full <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_full <= 1'b1;
            end else if (i_out_ready) begin
                r_out_full <= 1'b0;
            end
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_full;

    `WTM_ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, i_sts.div_done, r_state == S_WAIT)
    `WTM_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `WTM_ASSERT_IMP(a_idle_quiet, i_clk, i_rst_n, r_state == S_IDLE, !i_sts.div_busy)

endmodule

/* hdl/windowed_throughput_meter.sv */
// Windowed throughput meter: running byte total, periodic sampling into a
// 60-entry history ring, per-window byte rates with peak hold, stall tracking.
// Depends on wtm_pkg, wtm_ctrl and wtm_dp.
//
// Each request carries a byte count and the current time in ms and yields
// exactly one result: the wrapping 64-bit total, a flag that says whether the
// request took a sample, the four window rates and peaks, and the time at
// which the total stopped growing (0 while it grows). A sample is taken when
// now_ms minus the last sample time (modulo 2^48) reaches sample_period_ms.
// One request is worked on at a time. A request that takes no sample is
// captured, added, tested and loaded into the result register. In a sampling
// request each window reads its history record, forms bytes x 1000 in two add
// steps, and runs a one-bit-per-cycle 32-step divider shared by all windows.
// A window whose quotient saturates or whose time span is zero skips the
// divider steps. A window whose time span is zero keeps its rate and peak.
// Rates are floor(bytes x 1000 / ms), saturated to 32 bits. The result
// register lets the next request in while the previous result waits.
// History slots read as zero until first written; no clearing pass is needed.
// Configuration: index 0 is sample_period_ms, indexes 1 to 4 are window
// lengths a to d (0 acts as 1, above 60 acts as 60); other indexes are
// dropped. Write configuration only while the block is idle.
module windowed_throughput_meter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [wtm_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [wtm_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  wtm_pkg::t_wtm_in           i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output wtm_pkg::t_wtm_out          o_out_data
);
    import wtm_pkg::*;

    // command and status between the sequencer and the datapath
    t_wtm_cmd w_cmd;
    t_wtm_sts w_sts;

    // sequence each request and own the result handshake
    wtm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // hold state, history and arithmetic; drive the result register
    wtm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

endmodule

/* bench/windowed_throughput_meter_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for windowed_throughput_meter: directed table, then random traffic,
// stall and noise runs under several register settings, all scored against an in-bench predictor.
// Depends on wtm_pkg and the windowed_throughput_meter RTL.
module windowed_throughput_meter_tb;

    import wtm_pkg::*;

    localparam int CLK_HALF_NS     = 5;
    localparam int RESET_CYCLES    = 4;
    localparam int IDLE_PCT        = 21;
    localparam int PHASES          = 8;
    localparam int PHASE_REQUESTS  = 105;
    localparam int STEADY_PHASE    = 3;
    localparam int PAUSE_PHASE     = 2;
    // allow for a sampling request and for stalls on both sides
    localparam int STALL_LIMIT     = 4000;
    localparam int TAIL_CYCLES     = 200;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_PERIOD      = CFG_PERIOD;
    localparam logic [CFG_IW-1:0] REG_WIN_A       = CFG_WIN_FIRST;
    localparam logic [CFG_IW-1:0] REG_WIN_B       = CFG_WIN_FIRST + CFG_IW'(1);
    localparam logic [CFG_IW-1:0] REG_WIN_C       = CFG_WIN_FIRST + CFG_IW'(2);
    localparam logic [CFG_IW-1:0] REG_WIN_D       = CFG_WIN_FIRST + CFG_IW'(3);
    localparam logic [CFG_IW-1:0] REG_SPARE_FIRST = CFG_WIN_FIRST + CFG_IW'(WIN_COUNT);
    localparam logic [CFG_IW-1:0] REG_SPARE_LAST  = '1;

    // Directed step: either a register write or one request. Where typed is set,
    // total, sampled flag and stall time are the hand-worked values for that request.
    typedef struct packed {
        logic              is_write;
        logic [CFG_IW-1:0] reg_idx;
        logic [CFG_DW-1:0] reg_data;
        t_wtm_in           req;
        logic              typed;
        logic [BYTE_W-1:0] want_total;
        logic              want_sampled;
        logic [TIME_W-1:0] want_stall;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 26;

    // Reset settings first: period 1000, windows 1/5/20/60.
    t_directed_row directed_table [DIRECTED_ROWS] = '{
        // zero count at time zero: too early to sample
        '{1'b0, REG_PERIOD, 16'h0000, '{32'h0000_0000, 48'd0},
          1'b1, 64'h0000_0000_0000_0000, 1'b0, 48'd0},
        // full-scale count, one ms short of the period
        '{1'b0, REG_PERIOD, 16'h0000, '{32'hFFFF_FFFF, 48'd999},
          1'b1, 64'h0000_0000_FFFF_FFFF, 1'b0, 48'd0},
        // first sample: rate against empty history saturates
        '{1'b0, REG_PERIOD, 16'h0000, '{32'h0000_0001, 48'd1000},
          1'b1, 64'h0000_0001_0000_0000, 1'b1, 48'd0},
        // total flat across a sample: stall starts here
        '{1'b0, REG_PERIOD, 16'h0000, '{32'h0000_0000, 48'd2000},
          1'b1, 64'h0000_0001_0000_0000, 1'b1, 48'd2000},
        // still flat: stall start holds
        '{1'b0, REG_PERIOD, 16'h0000, '{32'h0000_0000, 48'd3000},
          1'b1, 64'h0000_0001_0000_0000, 1'b1, 48'd2000},
        // bytes arrive between samples: no sample, stall untouched
        '{1'b0, REG_PERIOD, 16'h0000, '{32'h0000_0005, 48'd3500},
          1'b1, 64'h0000_0001_0000_0005, 1'b0, 48'd2000},
        // next sample sees growth: stall clears
        '{1'b0, REG_PERIOD, 16'h0000, '{32'h0000_0000, 48'd4000},
          1'b1, 64'h0000_0001_0000_0005, 1'b1, 48'd0},
        // period zero, window a zero, window d above the ring, spare indexes
        '{1'b1, REG_PERIOD,      16'h0000, '{32'h0, 48'd0}, 1'b0, 64'd0, 1'b0, 48'd0},
        '{1'b1, REG_WIN_A,       16'h0000, '{32'h0, 48'd0}, 1'b0, 64'd0, 1'b0, 48'd0},
        '{1'b1, REG_WIN_D,       16'hFFFF, '{32'h0, 48'd0}, 1'b0, 64'd0, 1'b0, 48'd0},
        '{1'b1, REG_SPARE_FIRST, 16'hFFFF, '{32'h0, 48'd0}, 1'b0, 64'd0, 1'b0, 48'd0},
        '{1'b1, REG_SPARE_LAST,  16'h0000, '{32'h0, 48'd0}, 1'b0, 64'd0, 1'b0, 48'd0},
        // same time as the last sample: samples, but the one-sample window spans zero ms
        '{1'b0, REG_PERIOD, 16'h0000, '{32'h0000_0007, 48'd4000},
          1'b1, 64'h0000_0001_0000_000C, 1'b1, 48'd0},
        '{1'b0, REG_PERIOD, 16'h0000, '{32'h0000_0000, 48'd4000},
          1'b1, 64'h0000_0001_0000_000C, 1'b1, 48'd4000},
        // largest period
        '{1'b1, REG_PERIOD, 16'hFFFF, '{32'h0, 48'd0}, 1'b0, 64'd0, 1'b0, 48'd0},
        // latest possible time
        '{1'b0, REG_PERIOD, 16'h0000, '{32'h0000_0000, 48'hFFFF_FFFF_FFFF},
          1'b1, 64'h0000_0001_0000_000C, 1'b1, 48'd4000},
        // time wraps: only 101 ms have passed
        '{1'b0, REG_PERIOD, 16'h0000, '{32'h0000_0001, 48'd100},
          1'b1, 64'h0000_0001_0000_000D, 1'b0, 48'd4000},
        // exactly one period across the wrap
        '{1'b0, REG_PERIOD, 16'h0000, '{32'h0000_0000, 48'd65534},
          1'b1, 64'h0000_0001_0000_000D, 1'b1, 48'd0},
        // shortest period, mixed windows; upper data bits of window c are dropped
        '{1'b1, REG_PERIOD, 16'h0001, '{32'h0, 48'd0}, 1'b0, 64'd0, 1'b0, 48'd0},
        '{1'b1, REG_WIN_A,  16'h0001, '{32'h0, 48'd0}, 1'b0, 64'd0, 1'b0, 48'd0},
        '{1'b1, REG_WIN_B,  16'd60,   '{32'h0, 48'd0}, 1'b0, 64'd0, 1'b0, 48'd0},
        '{1'b1, REG_WIN_C,  16'hFFDE, '{32'h0, 48'd0}, 1'b0, 64'd0, 1'b0, 48'd0},
        '{1'b1, REG_WIN_D,  16'h003F, '{32'h0, 48'd0}, 1'b0, 64'd0, 1'b0, 48'd0},
        '{1'b0, REG_PERIOD, 16'h0000, '{32'h8000_0000, 48'd70000},
          1'b0, 64'd0, 1'b0, 48'd0},
        '{1'b0, REG_PERIOD, 16'h0000, '{32'h0000_1234, 48'd70001},
          1'b0, 64'd0, 1'b0, 48'd0},
        // no time passed: no sample
        '{1'b0, REG_PERIOD, 16'h0000, '{32'h0000_0000, 48'd70001},
          1'b1, 64'h0000_0001_8000_1241, 1'b0, 48'd0}
    };

    // DUT ports; the inputs are known from time zero
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [CFG_IW-1:0] i_cfg_idx   = '0;
    logic [CFG_DW-1:0] i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_wtm_in           i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_wtm_out          o_out_data;

    // predictor state: settings, running total, sample history, rates
    logic [PERIOD_W-1:0] sample_period;
    logic [WLEN_W-1:0]   win_len    [WIN_COUNT];
    logic [BYTE_W-1:0]   run_total;
    logic [TIME_W-1:0]   last_sample_ms;
    logic [TIME_W-1:0]   ring_time  [HIST_DEPTH];
    logic [BYTE_W-1:0]   ring_bytes [HIST_DEPTH];
    int                  ring_head;
    logic [TIME_W-1:0]   stall_start;
    logic [RATE_W-1:0]   cur_rate   [WIN_COUNT];
    logic [RATE_W-1:0]   peak_rate  [WIN_COUNT];

    t_wtm_out owed_results [$];   // results the meter still owes, oldest first
    t_wtm_out owed;

    bit steady = 1'b0;            // suppress idling on both sides
    int requests_sent = 0;
    int samples_seen  = 0;
    int reg_writes    = 0;
    int failures      = 0;
    int quiet_cycles  = 0;

    windowed_throughput_meter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #CLK_HALF_NS i_clk = ~i_clk;

    // Advance the predictor by one request and return the result it owes.
    function automatic t_wtm_out meter_step(input t_wtm_in req);
        t_wtm_out          res;
        logic [TIME_W-1:0] since_last;
        logic [TIME_W-1:0] span;
        logic [BYTE_W-1:0] gained;
        logic [NUM_W-1:0]  quot;
        logic              fire;
        int                newest;
        int                w;
        int                slot;
        int                i;
        res = '0;
        run_total  = run_total + BYTE_W'(req.byte_count);
        since_last = req.now_ms - last_sample_ms;
        fire       = since_last >= TIME_W'(sample_period);
        if (fire) begin
            newest = (ring_head + HIST_DEPTH - 1) % HIST_DEPTH;
            last_sample_ms = req.now_ms;
            // stall start marks the first flat sample; growth clears it
            if (run_total == ring_bytes[newest]) begin
                if (stall_start == '0)
                    stall_start = req.now_ms;
            end else begin
                stall_start = '0;
            end
            for (i = 0; i < WIN_COUNT; i++) begin
                w = int'(win_len[i]);
                if (w < 1)
                    w = 1;
                if (w > HIST_DEPTH)
                    w = HIST_DEPTH;
                slot = (ring_head + HIST_DEPTH - w) % HIST_DEPTH;
                span = req.now_ms - ring_time[slot];
                // zero span: keep rate and peak as they are
                if (span != '0) begin
                    gained = run_total - ring_bytes[slot];
                    quot   = (NUM_W'(gained) * NUM_W'(1000)) / NUM_W'(span);
                    cur_rate[i] = (|quot[NUM_W-1:RATE_W]) ? '1 : quot[RATE_W-1:0];
                    if (cur_rate[i] > peak_rate[i])
                        peak_rate[i] = cur_rate[i];
                end
            end
            ring_time[ring_head]  = req.now_ms;
            ring_bytes[ring_head] = run_total;
            ring_head = (ring_head + 1) % HIST_DEPTH;
        end
        res.total_received = run_total;
        res.sampled        = fire;
        res.rate_a         = cur_rate[0];
        res.rate_b         = cur_rate[1];
        res.rate_c         = cur_rate[2];
        res.rate_d         = cur_rate[3];
        res.peak_a         = peak_rate[0];
        res.peak_b         = peak_rate[1];
        res.peak_c         = peak_rate[2];
        res.peak_d         = peak_rate[3];
        res.stall_since_ms = stall_start;
        return res;
    endfunction

    function automatic logic [CNT_W-1:0] random_count();
        case ($urandom_range(0, 3))
            0:       return CNT_W'($urandom_range(0, 1500));
            1:       return CNT_W'($urandom_range(0, 65535));
            2:       return $urandom();
            default: return '0;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            failures++;
        end
    endtask

    // Write one register and mirror it in the predictor. Only call while idle.
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_PERIOD)
            sample_period = data[PERIOD_W-1:0];
        else if (idx >= REG_WIN_A && idx <= REG_WIN_D)
            win_len[idx - REG_WIN_A] = data[WLEN_W-1:0];
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Drop valid and hold until every owed result has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (owed_results.size() != 0);
    endtask

    // Offer one request, possibly after a random gap, and hold it until accepted.
    // On acceptance, advance the predictor; typed values override the predicted ones.
    task automatic send_request(input t_wtm_in req, input bit typed,
                                input logic [BYTE_W-1:0] want_total,
                                input logic want_sampled,
                                input logic [TIME_W-1:0] want_stall);
        t_wtm_out res;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        res = meter_step(req);
        if (typed) begin
            res.total_received = want_total;
            res.sampled        = want_sampled;
            res.stall_since_ms = want_stall;
        end
        owed_results.push_back(res);
        requests_sent++;
    endtask

    // Result side: stall at random, score every accepted result against the oldest owed one.
    always @(posedge i_clk) begin
        i_out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_results.size() == 0) begin
                $display("%0t: result with nothing owed, expected none, got %0h",
                         $time, o_out_data);
                failures++;
            end else begin
                owed = owed_results.pop_front();
                check_field("total_received", owed.total_received, o_out_data.total_received);
                check_field("sampled",        owed.sampled,        o_out_data.sampled);
                check_field("rate_a",         owed.rate_a,         o_out_data.rate_a);
                check_field("rate_b",         owed.rate_b,         o_out_data.rate_b);
                check_field("rate_c",         owed.rate_c,         o_out_data.rate_c);
                check_field("rate_d",         owed.rate_d,         o_out_data.rate_d);
                check_field("peak_a",         owed.peak_a,         o_out_data.peak_a);
                check_field("peak_b",         owed.peak_b,         o_out_data.peak_b);
                check_field("peak_c",         owed.peak_c,         o_out_data.peak_c);
                check_field("peak_d",         owed.peak_d,         o_out_data.peak_d);
                check_field("stall_since_ms", owed.stall_since_ms, o_out_data.stall_since_ms);
                if (owed.sampled)
                    samples_seen++;
            end
        end
    end

    // Watchdog: end the run when neither side has moved anything for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL windowed_throughput_meter");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_wtm_in             req;
        logic [TIME_W-1:0]   now_cursor;
        logic [PERIOD_W-1:0] period_sel;
        logic [WLEN_W-1:0]   win_sel [WIN_COUNT];
        logic [CFG_DW-1:0]   win_data;
        int unsigned         step_top;
        int                  phase;
        int                  left;
        int                  run_len;
        int                  kind;
        int                  k;
        int                  n;
        bit                  paused;

        // predictor comes out of reset with the block's reset settings
        sample_period  = 16'd1000;
        win_len[0]     = 6'd1;
        win_len[1]     = 6'd5;
        win_len[2]     = 6'd20;
        win_len[3]     = 6'd60;
        run_total      = '0;
        last_sample_ms = '0;
        ring_head      = 0;
        stall_start    = '0;
        for (k = 0; k < HIST_DEPTH; k++) begin
            ring_time[k]  = '0;
            ring_bytes[k] = '0;
        end
        for (k = 0; k < WIN_COUNT; k++) begin
            cur_rate[k]  = '0;
            peak_rate[k] = '0;
        end
        paused = 1'b0;

        // hold reset, then release it once
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Register writes wait for the meter to drain first.
        for (k = 0; k < DIRECTED_ROWS; k++) begin
            if (directed_table[k].is_write) begin
                wait_for_results();
                write_reg(directed_table[k].reg_idx, directed_table[k].reg_data);
            end else begin
                send_request(directed_table[k].req, directed_table[k].typed,
                             directed_table[k].want_total, directed_table[k].want_sampled,
                             directed_table[k].want_stall);
            end
        end
        now_cursor = 48'd70001;

        // Random part: one register setting per phase, each phase a mix of
        // traffic runs, flat-total runs and noise.
        for (phase = 0; phase < PHASES; phase++) begin
            wait_for_results();
            for (k = 0; k < WIN_COUNT; k++)
                win_sel[k] = WLEN_W'($urandom_range(1, HIST_DEPTH));
            case (phase)
                0: period_sel = 16'd1;
                1: begin
                    // window extremes, including the ones that clamp
                    period_sel = 16'd0;
                    win_sel[0] = 6'd0;
                    win_sel[1] = 6'd63;
                    win_sel[2] = 6'd1;
                    win_sel[3] = 6'd60;
                end
                2: period_sel = 16'hFFFF;
                3: period_sel = PERIOD_W'($urandom_range(2, 50));
                4: begin
                    period_sel = 16'd1000;
                    win_sel[0] = 6'd1;
                    win_sel[1] = 6'd5;
                    win_sel[2] = 6'd20;
                    win_sel[3] = 6'd60;
                end
                5: period_sel = PERIOD_W'($urandom_range(1, 65535));
                6: begin
                    period_sel = PERIOD_W'($urandom_range(1, 8));
                    for (k = 0; k < WIN_COUNT; k++)
                        win_sel[k] = WLEN_W'($urandom_range(0, 63));
                end
                default: begin
                    period_sel = 16'd1;
                    for (k = 0; k < WIN_COUNT; k++)
                        win_sel[k] = WLEN_W'(HIST_DEPTH);
                end
            endcase
            write_reg(REG_PERIOD, period_sel);
            for (k = 0; k < WIN_COUNT; k++) begin
                // random upper data bits must not leak into the window length
                win_data = (phase == 6) ? {10'($urandom()), win_sel[k]} : CFG_DW'(win_sel[k]);
                write_reg(REG_WIN_A + CFG_IW'(k), win_data);
            end
            if (phase == 1 || phase == PHASES - 1) begin
                for (k = int'(REG_SPARE_FIRST); k <= int'(REG_SPARE_LAST); k++)
                    write_reg(CFG_IW'(k), CFG_DW'($urandom()));
            end

            steady   = (phase == STEADY_PHASE);
            step_top = int'(period_sel) + int'(period_sel) / 4 + 1;
            left     = PHASE_REQUESTS;
            while (left > 0) begin
                kind = $urandom_range(0, 99);
                if (kind < 60)
                    run_len = $urandom_range(5, 20);
                else if (kind < 85)
                    run_len = $urandom_range(5, 15);
                else
                    run_len = $urandom_range(1, 4);
                if (run_len > left)
                    run_len = left;
                for (n = 0; n < run_len; n++) begin
                    if (kind < 85) begin
                        // traffic or flat run: time moves forward by up to a bit over a period
                        now_cursor     = now_cursor + TIME_W'($urandom_range(0, step_top));
                        req.now_ms     = now_cursor;
                        req.byte_count = (kind < 60) ? random_count() : '0;
                    end else begin
                        // noise: arbitrary time, repeated time, time going back, near the wrap
                        case ($urandom_range(0, 3))
                            0:       req.now_ms = TIME_W'({$urandom(), $urandom()});
                            1:       req.now_ms = now_cursor;
                            2:       req.now_ms = now_cursor - TIME_W'($urandom_range(1, 5000));
                            default: req.now_ms = '1 - TIME_W'($urandom_range(0, 3));
                        endcase
                        now_cursor     = req.now_ms;
                        req.byte_count = random_count();
                    end
                    send_request(req, 1'b0, '0, 1'b0, '0);
                    left--;
                end
                // let the meter run dry once in the middle of a phase
                if (phase == PAUSE_PHASE && !paused && left < PHASE_REQUESTS / 2) begin
                    wait_for_results();
                    paused = 1'b1;
                end
            end
        end
        steady = 1'b0;

        // drain, then give a stray result time to show up
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests (%0d took a sample) over %0d register settings,",
                 requests_sent, samples_seen, PHASES + 4);
        $display("with %0d register writes; %0d failures.", reg_writes, failures);
        if (failures == 0 && owed_results.size() == 0) begin
            $display("PASS windowed_throughput_meter");
        end else begin
            $display("FAIL windowed_throughput_meter");
        end
        $finish;
    end

endmodule
